/* rtl/dfs_maze_carver_defines.svh */
// Assertion macros shared by the maze carver RTL.
`ifndef DFS_MAZE_CARVER_DEFINES_SVH
`define DFS_MAZE_CARVER_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge of ck, ignored while rs is high.
`define DMC_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("dmc: assertion failed");

// Same check with a caller-supplied message string.
`define DMC_ASSERT_MSG(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error(msg);

`else

`define DMC_ASSERT(lbl, ck, rs, prop)
`define DMC_ASSERT_MSG(lbl, ck, rs, prop, msg)

`endif

`endif

/* rtl/dmc_pkg.sv */
package dmc_pkg;

  // Field widths fixed by the interface.
  localparam int ROW_W      = 4;
  localparam int COL_W      = 6;
  localparam int RND_W      = 16;
  localparam int ROWS_CFG_W = 5;
  localparam int COLS_CFG_W = 7;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  // Register select (paddr bit 2) and reset values.
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 5'd14;
  localparam logic [COLS_CFG_W-1:0] COLS_RESET = 7'd59;

  // Opcodes.
  localparam logic OP_CARVE   = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_CARVED    = 2'd0;
  localparam logic [1:0] KIND_BACKTRACK = 2'd1;
  localparam logic [1:0] KIND_FINISHED  = 2'd2;
  localparam logic [1:0] KIND_RESTARTED = 2'd3;

  // Directions, also the neighbour scan order.
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_UP    = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic take_in;   // latch the input word
    logic rd_vert;   // read down/up neighbours, hold right/left results
    logic decide;    // pick the move and update maze state
    logic load_out;  // move the result into the output register
    logic clear;     // write one visited-map entry of the clearing sweep
  } dmc_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic restart;     // latched word is a restart
    logic out_free;    // output register can take a result this cycle
    logic clear_last;  // clearing sweep is at its last entry
  } dmc_stat_t;

endpackage

/* rtl/dmc_ctrl.sv */
`include "dfs_maze_carver_defines.svh"

module dmc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_valid,
  output logic               step_stall,
  output dmc_pkg::dmc_cmd_t  cmd,
  input  dmc_pkg::dmc_stat_t stat
);
  import dmc_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.take_in = step_valid;
        if (step_valid) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_vert = 1'b1;
        state_next  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.load_out = stat.out_free;
        if (stat.out_free) begin
          state_next = stat.restart ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign step_stall = (state != ST_IDLE);

  `DMC_ASSERT(a_read_then_decide, clk, rst, state == ST_READ |=> state == ST_DECIDE)
  `DMC_ASSERT(a_one_cmd, clk, rst, $onehot0({cmd.take_in, cmd.decide, cmd.load_out, cmd.clear}))
  `DMC_ASSERT_MSG(a_emit_leaves, clk, rst, (state == ST_EMIT) && stat.out_free |=> (state == ST_IDLE) || (state == ST_CLEAR), "dmc: emit did not leave")

endmodule

/* rtl/dmc_datapath.sv */
`include "dfs_maze_carver_defines.svh"

module dmc_datapath #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dmc_pkg::dmc_cmd_t               cmd,
  output dmc_pkg::dmc_stat_t              stat,
  input  logic [dmc_pkg::ROWS_CFG_W-1:0]  rows_cfg,
  input  logic [dmc_pkg::COLS_CFG_W-1:0]  cols_cfg,
  input  logic                            opcode,
  input  logic [dmc_pkg::RND_W-1:0]       random_value,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      kind,
  output logic [dmc_pkg::ROW_W-1:0]       from_row,
  output logic [dmc_pkg::COL_W-1:0]       from_col,
  output logic [dmc_pkg::ROW_W-1:0]       to_row,
  output logic [dmc_pkg::COL_W-1:0]       to_col,
  output logic [1:0]                      direction
);
  import dmc_pkg::*;

  localparam int RW     = $clog2(MAX_ROWS);
  localparam int CW     = $clog2(MAX_COLS);
  localparam int AW     = RW + CW;
  localparam int VDEPTH = 1 << AW;
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int SAW    = $clog2(CELLS);
  localparam int SCW    = $clog2(CELLS + 1);
  localparam logic [9:0] ROWS_MX = 10'(MAX_ROWS);
  localparam logic [9:0] COLS_MX = 10'(MAX_COLS);

  // v is inside a dimension of lim cells (zero counts as one) and of mx at most.
  function automatic logic in_dim(input logic [9:0] v, input logic [9:0] lim,
                                  input logic [9:0] mx);
    in_dim = (v < mx) && ((v < lim) || (v == 10'd0));
  endfunction

  // Remainder by three: base-4 digits sum to the same residue.
  function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    mod3 = t[1:0];
  endfunction

  // Direction of the n-th set bit of the candidate mask.
  function automatic logic [1:0] nth_set(input logic [3:0] m, input logic [1:0] n);
    logic [2:0] seen;
    logic [1:0] found;
    seen  = '0;
    found = '0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) begin
        if (seen == {1'b0, n}) begin
          found = 2'(i);
        end
        seen = seen + 3'd1;
      end
    end
    nth_set = found;
  endfunction

  logic            vis_mem [VDEPTH];
  logic [AW-1:0]   stk_mem [CELLS];

  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic            done_flag;
  logic [SCW-1:0]  stack_count;
  logic [AW-1:0]   clr_cnt;

  logic            op_r;
  logic [1:0]      rnd_lo;
  logic [1:0]      rnd_m3;
  logic            vis_a;
  logic            vis_b;
  logic [1:0]      nb_h;
  logic [AW-1:0]   stk_rd;

  logic [1:0]      res_kind;
  logic [ROW_W-1:0] res_from_row;
  logic [COL_W-1:0] res_from_col;
  logic [ROW_W-1:0] res_to_row;
  logic [COL_W-1:0] res_to_col;
  logic [1:0]      res_dir;

  logic [RW-1:0]   row_p, row_m;
  logic [CW-1:0]   col_p, col_m;
  logic            r_in, rp_in, rm_in, c_in, cp_in, cm_in;
  logic            right_ok, left_ok, down_ok, up_ok;
  logic [AW-1:0]   rd_addr_a, rd_addr_b;
  logic [3:0]      avail;
  logic [2:0]      cnt;
  logic [1:0]      pick;
  logic [1:0]      dir_sel;
  logic [RW-1:0]   nxt_row;
  logic [CW-1:0]   nxt_col;
  logic [SCW-1:0]  stk_dec;
  logic            carve;
  logic            push;

  assign row_p = cur_row + 1'b1;
  assign row_m = cur_row - 1'b1;
  assign col_p = cur_col + 1'b1;
  assign col_m = cur_col - 1'b1;

  // Bounds against the area in use; the row of a side move must also be inside.
  assign r_in  = in_dim(10'(cur_row), 10'(rows_cfg), ROWS_MX);
  assign rp_in = in_dim(10'(cur_row) + 10'd1, 10'(rows_cfg), ROWS_MX);
  assign rm_in = (cur_row != '0) && in_dim(10'(cur_row) - 10'd1, 10'(rows_cfg), ROWS_MX);
  assign c_in  = in_dim(10'(cur_col), 10'(cols_cfg), COLS_MX);
  assign cp_in = in_dim(10'(cur_col) + 10'd1, 10'(cols_cfg), COLS_MX);
  assign cm_in = (cur_col != '0) && in_dim(10'(cur_col) - 10'd1, 10'(cols_cfg), COLS_MX);

  assign right_ok = r_in && cp_in;
  assign left_ok  = r_in && cm_in;
  assign down_ok  = rp_in && c_in;
  assign up_ok    = rm_in && c_in;

  // Port a reads right then down, port b reads left then up.
  assign rd_addr_a = cmd.rd_vert ? {row_p, cur_col} : {cur_row, col_p};
  assign rd_addr_b = cmd.rd_vert ? {row_m, cur_col} : {cur_row, col_m};

  assign avail = {up_ok & ~vis_b, down_ok & ~vis_a, left_ok & ~nb_h[1], right_ok & ~nb_h[0]};
  assign cnt   = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);

  always_comb begin
    case (cnt)
      3'd2:    pick = {1'b0, rnd_lo[0]};
      3'd3:    pick = rnd_m3;
      3'd4:    pick = rnd_lo;
      default: pick = 2'd0;
    endcase
  end

  assign dir_sel = nth_set(avail, pick);

  always_comb begin
    case (dir_sel)
      DIR_RIGHT: begin
        nxt_row = cur_row;
        nxt_col = col_p;
      end
      DIR_LEFT: begin
        nxt_row = cur_row;
        nxt_col = col_m;
      end
      DIR_DOWN: begin
        nxt_row = row_p;
        nxt_col = cur_col;
      end
      default: begin
        nxt_row = row_m;
        nxt_col = cur_col;
      end
    endcase
  end

  assign stk_dec = stack_count - SCW'(1);
  assign carve   = cmd.decide && (op_r != OP_RESTART) && !done_flag && (cnt != 3'd0);
  assign push    = carve && (stack_count < SCW'(CELLS));

  // Visited map: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vis_mem[clr_cnt] <= (clr_cnt == '0);
    end else if (carve) begin
      vis_mem[{nxt_row, nxt_col}] <= 1'b1;
    end
    vis_a <= vis_mem[rd_addr_a];
    vis_b <= vis_mem[rd_addr_b];
  end

  // Path stack: read the top entry every cycle.
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[stack_count[SAW-1:0]] <= {cur_row, cur_col};
    end
    stk_rd <= stk_mem[stk_dec[SAW-1:0]];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row      <= '0;
      cur_col      <= '0;
      done_flag    <= 1'b0;
      stack_count  <= '0;
      clr_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.decide) begin
        if (op_r == OP_RESTART) begin
          cur_row     <= '0;
          cur_col     <= '0;
          stack_count <= '0;
          done_flag   <= 1'b0;
        end else if (!done_flag) begin
          if (cnt != 3'd0) begin
            cur_row <= nxt_row;
            cur_col <= nxt_col;
            if (push) begin
              stack_count <= stack_count + 1'b1;
            end
          end else if (stack_count == '0) begin
            done_flag <= 1'b1;
          end else begin
            stack_count <= stk_dec;
            cur_row     <= stk_rd[AW-1:CW];
            cur_col     <= stk_rd[CW-1:0];
          end
        end
      end
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      op_r   <= opcode;
      rnd_lo <= random_value[1:0];
      rnd_m3 <= mod3(random_value);
    end
    if (cmd.rd_vert) begin
      nb_h <= {vis_b, vis_a};
    end
    if (cmd.decide) begin
      res_from_row <= ROW_W'(cur_row);
      res_from_col <= COL_W'(cur_col);
      res_dir      <= DIR_RIGHT;
      if (op_r == OP_RESTART) begin
        res_kind   <= KIND_RESTARTED;
        res_to_row <= '0;
        res_to_col <= '0;
      end else if (done_flag || ((cnt == 3'd0) && (stack_count == '0))) begin
        res_kind   <= KIND_FINISHED;
        res_to_row <= ROW_W'(cur_row);
        res_to_col <= COL_W'(cur_col);
      end else if (cnt != 3'd0) begin
        res_kind   <= KIND_CARVED;
        res_to_row <= ROW_W'(nxt_row);
        res_to_col <= COL_W'(nxt_col);
        res_dir    <= dir_sel;
      end else begin
        res_kind   <= KIND_BACKTRACK;
        res_to_row <= ROW_W'(stk_rd[AW-1:CW]);
        res_to_col <= COL_W'(stk_rd[CW-1:0]);
      end
    end
    if (cmd.load_out) begin
      kind      <= res_kind;
      from_row  <= res_from_row;
      from_col  <= res_from_col;
      to_row    <= res_to_row;
      to_col    <= res_to_col;
      direction <= res_dir;
    end
  end

  assign stat.restart    = (op_r == OP_RESTART);
  assign stat.out_free   = !result_valid || !result_stall;
  assign stat.clear_last = &clr_cnt;

  `DMC_ASSERT(a_stack_bound, clk, rst, stack_count <= SCW'(CELLS))
  `DMC_ASSERT(a_done_empty, clk, rst, done_flag |-> stack_count == '0)
  `DMC_ASSERT_MSG(a_out_from_load, clk, rst, $rose(result_valid) |-> $past(cmd.load_out), "dmc: output rose without load")

endmodule

/* rtl/dfs_maze_carver.sv */
// Maze carver by randomized depth-first search (recursive backtracker). Each
// step word brings a 16-bit random value; the block looks at the unvisited,
// in-bounds neighbours of the current cell in the order right, left, down, up,
// picks one by random mod count, carves into it and pushes the old cell, or
// pops the stack to backtrack, or reports finished once the stack is empty.
// A restart word returns to cell (0,0) and clears the visited map. A carve
// or backtrack step runs through accept, neighbour read, decide and output
// load in turn; the output load waits while the output register is full and
// stalled, and the next step word is taken only once the result is loaded.
// The separate neighbour read is needed because the two-port visited-map
// memory returns two neighbour bits per cycle. A restart runs through the same
// steps and is then followed by a clearing sweep of the visited map, one entry
// per cycle, over 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (1024 with the
// defaults); the same sweep runs after reset. No step
// word is taken during the sweep, while APB writes are taken at any time.
// The output register holds one result, so a step word may be accepted while
// the previous result still waits on result_stall. Configuration is by APB:
// rows_in_use at byte address 0, cols_in_use at 4; a value of 0 acts as 1 and
// a value above MAX_ROWS or MAX_COLS acts as that maximum. Write them only
// while the block is idle.
module dfs_maze_carver #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmc_pkg::APB_AW-1:0]  paddr,
  input  logic [dmc_pkg::APB_DW-1:0]  pwdata,
  output logic [dmc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // step words in
  input  logic                        step_valid,
  output logic                        step_stall,
  input  logic                        opcode,
  input  logic [dmc_pkg::RND_W-1:0]   random_value,
  // result words out
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [1:0]                  kind,
  output logic [dmc_pkg::ROW_W-1:0]   from_row,
  output logic [dmc_pkg::COL_W-1:0]   from_col,
  output logic [dmc_pkg::ROW_W-1:0]   to_row,
  output logic [dmc_pkg::COL_W-1:0]   to_col,
  output logic [1:0]                  direction
);
  import dmc_pkg::*;

  logic [ROWS_CFG_W-1:0] rows_in_use;
  logic [COLS_CFG_W-1:0] cols_in_use;
  logic                  reg_sel;
  logic                  cfg_wr;

  dmc_cmd_t  cmd;
  dmc_stat_t stat;

  // Registers sit on 4-byte boundaries; decode the word address only.
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      cols_in_use <= COLS_RESET;
    end else if (cfg_wr) begin
      if (reg_sel == REG_ROWS) begin
        rows_in_use <= pwdata[ROWS_CFG_W-1:0];
      end else begin
        cols_in_use <= pwdata[COLS_CFG_W-1:0];
      end
    end
  end

  // Read back the raw register value, zero-extended.
  assign prdata = (reg_sel == REG_COLS) ? APB_DW'(cols_in_use) : APB_DW'(rows_in_use);

  // Sequencer: clear sweep, accept, read neighbours, decide, emit.
  dmc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_valid),
    .step_stall (step_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Visited map, path stack, current cell and the output register.
  dmc_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .rows_cfg     (rows_in_use),
    .cols_cfg     (cols_in_use),
    .opcode       (opcode),
    .random_value (random_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .from_row     (from_row),
    .from_col     (from_col),
    .to_row       (to_row),
    .to_col       (to_col),
    .direction    (direction)
  );

endmodule

/* tb/sv/tb_dfs_maze_carver.sv */
`timescale 1ns / 100ps

module tb_dfs_maze_carver;
  import dmc_pkg::*;

  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLS    = 64;
  localparam int CELLS       = MAX_ROWS * MAX_COLS;
  localparam int CELL_W      = ROW_W + COL_W;
  localparam int CYCLE_LIMIT = 600000;
  // Leave room after the last carve step before touching registers.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 1000;
  // Switch off idling on both sides for the tail of the run.
  localparam int QUIET_AFTER  = 850;

  localparam logic [APB_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};

  // Neighbour offsets in scan order: right, left, down, up.
  localparam int ROW_STEP [4] = '{0, 0, 1, -1};
  localparam int COL_STEP [4] = '{1, -1, 0, 0};

  typedef struct packed {
    logic             op;
    logic [RND_W-1:0] rnd;
  } step_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ROW_W-1:0] from_row;
    logic [COL_W-1:0] from_col;
    logic [ROW_W-1:0] to_row;
    logic [COL_W-1:0] to_col;
    logic [1:0]       direction;
  } maze_move_t;

  logic                clk;
  logic                rst          = 1'b1;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [APB_AW-1:0]   paddr        = '0;
  logic [APB_DW-1:0]   pwdata       = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                step_valid   = 1'b0;
  logic                step_stall;
  logic                opcode       = OP_CARVE;
  logic [RND_W-1:0]    random_value = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [1:0]          kind;
  logic [ROW_W-1:0]    from_row;
  logic [COL_W-1:0]    from_col;
  logic [ROW_W-1:0]    to_row;
  logic [COL_W-1:0]    to_col;
  logic [1:0]          direction;

  dfs_maze_carver #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .step_valid   (step_valid),
    .step_stall   (step_stall),
    .opcode       (opcode),
    .random_value (random_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .from_row     (from_row),
    .from_col     (from_col),
    .to_row       (to_row),
    .to_col       (to_col),
    .direction    (direction)
  );

  // Own copy of the maze: visited bits, backtrack stack, position and area registers.
  bit                     visited_cells [CELLS];
  logic [ROW_W+COL_W-1:0] trail [CELLS];
  int                     trail_depth;
  logic [ROW_W+COL_W-1:0] here;
  bit                     maze_done;
  int                     rows_reg = int'(ROWS_RESET);
  int                     cols_reg = int'(COLS_RESET);

  step_word_t step_words [$];     // words waiting to be driven
  maze_move_t pending_moves [$];  // predicted moves, oldest first

  step_word_t next_word;
  int  gap_left    = 0;
  int  stall_left  = 0;
  bit  quiet       = 1'b0;
  int  fail_count  = 0;
  int  words_taken = 0;
  int  queued      = 0;
  int  kind_seen [4];
  longint cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A value of 0 behaves as 1, anything above the maximum as the maximum.
  function automatic int clamp_dim(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void clear_maze();
    foreach (visited_cells[i]) visited_cells[i] = 1'b0;
    visited_cells[0] = 1'b1;
    trail_depth = 0;
    here = '0;
    maze_done = 1'b0;
  endfunction

  // Work out the move one accepted step word causes and advance the maze copy.
  function automatic maze_move_t advance_maze(logic op, logic [RND_W-1:0] rnd);
    maze_move_t m;
    int rows_eff, cols_eff, r, c, nr, nc, n, pick;
    int cand_cell [4];
    int cand_dir [4];
    m = '0;
    m.from_row = here[COL_W +: ROW_W];
    m.from_col = here[COL_W-1:0];
    rows_eff = clamp_dim(rows_reg, MAX_ROWS);
    cols_eff = clamp_dim(cols_reg, MAX_COLS);
    r = int'(here) / MAX_COLS;
    c = int'(here) % MAX_COLS;
    if (op == OP_RESTART) begin
      clear_maze();
      m.kind = KIND_RESTARTED;
    end else if (maze_done) begin
      m.kind = KIND_FINISHED;
    end else begin
      n = 0;
      for (int d = 0; d < 4; d++) begin
        nr = r + ROW_STEP[d];
        nc = c + COL_STEP[d];
        if (nr >= 0 && nc >= 0 && nr < rows_eff && nc < cols_eff &&
            !visited_cells[nr * MAX_COLS + nc]) begin
          cand_cell[n] = nr * MAX_COLS + nc;
          cand_dir[n]  = d;
          n++;
        end
      end
      if (n > 0) begin
        pick = int'(rnd) % n;
        // Push is dropped on a full stack, which a legal walk never reaches.
        if (trail_depth < CELLS) begin
          trail[trail_depth] = here;
          trail_depth++;
        end
        visited_cells[cand_cell[pick]] = 1'b1;
        here = CELL_W'(cand_cell[pick]);
        m.kind = KIND_CARVED;
        m.direction = 2'(cand_dir[pick]);
      end else if (trail_depth == 0) begin
        // Nothing left to carve and nowhere to return: the maze is complete.
        maze_done = 1'b1;
        m.kind = KIND_FINISHED;
      end else begin
        trail_depth--;
        here = trail[trail_depth];
        m.kind = KIND_BACKTRACK;
      end
    end
    m.to_row = here[COL_W +: ROW_W];
    m.to_col = here[COL_W-1:0];
    return m;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic void queue_word(logic op, logic [RND_W-1:0] rnd);
    step_word_t w;
    w.op  = op;
    w.rnd = rnd;
    step_words = {step_words, w};
    queued++;
  endfunction

  // Step driver: hold a stalled word, otherwise advance to the next one or idle a burst.
  always @(posedge clk) begin
    if (rst) begin
      step_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (step_valid && !step_stall) begin
        pending_moves = {pending_moves, advance_maze(opcode, random_value)};
        words_taken++;
      end
      if (!step_valid || !step_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          step_valid <= 1'b0;
        end else if (step_words.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
          gap_left = $urandom_range(0, 4);
          step_valid <= 1'b0;
        end else if (step_words.size() > 0) begin
          next_word = step_words.pop_front();
          opcode       <= next_word.op;
          random_value <= next_word.rnd;
          step_valid   <= 1'b1;
        end else begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted word against the oldest prediction, stall in bursts.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_moves.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual kind %0d", $time, kind);
          fail_count++;
        end else begin
          maze_move_t want;
          want = pending_moves.pop_front();
          check_field("kind",      want.kind,      kind);
          check_field("from_row",  want.from_row,  from_row);
          check_field("from_col",  want.from_col,  from_col);
          check_field("to_row",    want.to_row,    to_row);
          check_field("to_col",    want.to_col,    to_col);
          check_field("direction", want.direction, direction);
          kind_seen[want.kind]++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 4);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d moves outstanding", $time, pending_moves.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Setup cycle, then access cycle; the register takes the word at the edge with pready high.
  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both area registers; upper data bits carry noise the register must drop.
  task automatic set_area(int rows, int cols);
    apb_write(ADDR_ROWS, ($urandom & ~32'h1f) | rows[ROWS_CFG_W-1:0]);
    rows_reg = rows & 32'h1f;
    apb_write(ADDR_COLS, ($urandom & ~32'h7f) | cols[COLS_CFG_W-1:0]);
    cols_reg = cols & 32'h7f;
  endtask

  // Wait until every queued word is taken and answered, then let the pipe drain.
  task automatic settle();
    @(negedge clk);
    while (step_words.size() > 0 || step_valid || pending_moves.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int rows, int cols);
    int area, n;
    area = clamp_dim(rows, MAX_ROWS) * clamp_dim(cols, MAX_COLS);
    n = $urandom_range(4, (2 * area + 4 > 120) ? 120 : 2 * area + 4);
    set_area(rows, cols);
    // Mostly start from a fresh maze; sometimes keep the old walk in the new area.
    if ($urandom_range(0, 9) < 7) queue_word(OP_RESTART, RND_W'($urandom_range(0, 65535)));
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) queue_word(OP_RESTART, RND_W'($urandom_range(0, 65535)));
      else queue_word(OP_CARVE, RND_W'($urandom_range(0, 65535)));
    end
    settle();
  endtask

  initial begin
    int pick, rows, cols;
    clear_maze();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset area, random value extremes and a restart in the middle of a walk.
    queue_word(OP_CARVE, 16'h0000);
    queue_word(OP_CARVE, 16'hffff);
    queue_word(OP_CARVE, 16'h5555);
    queue_word(OP_CARVE, 16'haaaa);
    queue_word(OP_RESTART, 16'hffff);
    queue_word(OP_CARVE, 16'h0001);
    settle();

    // Zero registers act as a single cell: back up to the start, then finished until a restart.
    set_area(0, 0);
    queue_word(OP_CARVE, 16'h1234);
    queue_word(OP_CARVE, 16'hffff);
    queue_word(OP_RESTART, 16'h0000);
    queue_word(OP_CARVE, 16'h0000);
    settle();

    // One row of two cells: carve right, back up, then finish.
    set_area(1, 2);
    queue_word(OP_RESTART, 16'h8000);
    queue_word(OP_CARVE, 16'h0003);
    queue_word(OP_CARVE, 16'h0007);
    queue_word(OP_CARVE, 16'h0000);
    settle();

    // Oversized registers clamp to the full grid.
    set_area(31, 127);
    queue_word(OP_RESTART, 16'h0000);
    queue_word(OP_CARVE, 16'h0003);
    queue_word(OP_CARVE, 16'h0002);
    queue_word(OP_CARVE, 16'h0001);
    settle();

    // Shrink the area mid-walk: the current cell and stack stay as they are.
    set_area(2, 3);
    repeat (4) queue_word(OP_CARVE, RND_W'($urandom_range(0, 65535)));
    settle();

    queued = 0;
    while (queued < RANDOM_WORDS) begin
      if (queued >= QUIET_AFTER) quiet = 1'b1;
      pick = $urandom_range(0, 9);
      case (pick)
        0: begin
          rows = $urandom_range(0, 31);
          cols = $urandom_range(0, 127);
        end
        1: begin
          rows = ($urandom_range(0, 1) != 0) ? MAX_ROWS : 1;
          cols = ($urandom_range(0, 1) != 0) ? MAX_COLS : 1;
        end
        default: begin
          rows = $urandom_range(1, 5);
          cols = $urandom_range(1, 8);
        end
      endcase
      random_phase(rows, cols);
    end

    settle();
    $display("checked %0d step words: %0d carved, %0d backtracked, %0d finished, %0d restarts",
             words_taken, kind_seen[KIND_CARVED], kind_seen[KIND_BACKTRACK],
             kind_seen[KIND_FINISHED], kind_seen[KIND_RESTARTED]);
    $display("areas from one cell to the full grid, with zero and oversized registers");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
